// ===== design/sdm_pkg.sv =====
// Package for the scrolling 14-segment display driver.
// Holds the font ROM, the fixed message text and the lookup functions.
// No dependencies.
package sdm_pkg;

  localparam int MsgChars = 8;
  localparam int MsgCount = 4;
  localparam int StoredMsgs = 4;
  localparam int StoredChars = 8;

  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MUX_DIVIDE    = 1'b0,
    CFG_SCROLL_DIVIDE = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ACT_TICK   = 1'b0,
    ACT_SELECT = 1'b1
  } action_e;

  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;
  localparam logic [7:0] ChrUpA   = 8'h41;
  localparam logic [7:0] ChrUpZ   = 8'h5a;

  localparam logic [13:0] FONT_ROM [36] = '{
    14'h0c3f, 14'h0406, 14'h00db, 14'h008f, 14'h00e6, 14'h00ed, 14'h00fd, 14'h1401,
    14'h00ff, 14'h00e7, 14'h00f7, 14'h128f, 14'h0039, 14'h120f, 14'h00f9, 14'h00f1,
    14'h00bd, 14'h00f6, 14'h1209, 14'h001e, 14'h2470, 14'h0038, 14'h0536, 14'h2136,
    14'h003f, 14'h00f3, 14'h203f, 14'h20f3, 14'h018d, 14'h1201, 14'h003e, 14'h0c30,
    14'h2836, 14'h2d00, 14'h1500, 14'h0c09
  };

  // ERROR, AUTO, MANUAL, STOP; zero pads the tail
  localparam logic [7:0] MSG_TEXT [StoredMsgs][StoredChars] = '{
    '{8'h45, 8'h52, 8'h52, 8'h4f, 8'h52, 8'h00, 8'h00, 8'h00},
    '{8'h41, 8'h55, 8'h54, 8'h4f, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4d, 8'h41, 8'h4e, 8'h55, 8'h41, 8'h4c, 8'h00, 8'h00},
    '{8'h53, 8'h54, 8'h4f, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] MSG_LEN [StoredMsgs] = '{4'd5, 4'd4, 4'd6, 4'd4};

  function automatic logic msg_valid(input logic [3:0] sel);
    return (int'(sel) < MsgCount) && (int'(sel) < StoredMsgs);
  endfunction

  function automatic logic [3:0] msg_length(input logic [3:0] sel);
    logic [3:0] n;
    n = 4'd0;
    if (msg_valid(sel)) begin
      n = MSG_LEN[sel[1:0]];
      if (int'(n) > MsgChars) n = 4'(MsgChars);
    end
    return n;
  endfunction

  function automatic logic [7:0] char_at(input logic [3:0] sel, input logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (msg_valid(sel) && int'(pos) < MsgChars && int'(pos) < StoredChars) begin
      c = MSG_TEXT[sel[1:0]][pos[2:0]];
    end
    return c;
  endfunction

  function automatic logic [13:0] font_lookup(input logic [7:0] c);
    logic [7:0] ofs;
    logic [13:0] seg;
    seg = '0;
    ofs = '0;
    if (c >= ChrZero && c <= ChrNine) begin
      ofs = c - ChrZero;
      seg = FONT_ROM[ofs[5:0]];
    end else if (c >= ChrUpA && c <= ChrUpZ) begin
      ofs = c - ChrUpA + 8'd10;
      seg = FONT_ROM[ofs[5:0]];
    end
    return seg;
  endfunction

endpackage

// ===== design/sdm_if.sv =====
// Handshake channel interfaces of the scrolling 14-segment display driver.
// Depends on sdm_pkg for the configuration port widths.
interface sdm_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [3:0] select_value;
  modport source (output valid, action, select_value, input ready);
  modport sink (input valid, action, select_value, output ready);
endinterface

interface sdm_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  digit_enable_n;
  logic [13:0] segments;
  modport source (output valid, digit_enable_n, segments, input ready);
  modport sink (input valid, digit_enable_n, segments, output ready);
endinterface

interface sdm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sdm_pkg::CfgIdxW-1:0]  index;
  logic [sdm_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/scrolling_14seg_display_mux.sv =====
// Scrolling 14-segment display driver, top level.
// Depends on sdm_pkg and the channel interfaces in sdm_if.sv.
//
// Takes one item per clock: a timer tick or a message selector sample. Each
// item is resolved in the cycle it is accepted and any digit it drives is
// held in a single output register, so the block accepts an item every cycle
// as long as the output register is empty or being read; a driven digit is
// visible in the cycle after its acceptance. Every mux_divide ticks one
// digit is driven (one-cold enable plus font pattern) and the digit index
// advances; every scroll_divide driven digits the scroll offset steps and
// wraps once the window passes the end of the message. A changed selector
// value restarts the scroll; selections past the stored messages show blanks.
// Configuration writes are always taken and must only arrive while idle.
module scrolling_14seg_display_mux (
  input  logic clk_i,
  input  logic rst_ni,
  sdm_in_if.sink    in_i,
  sdm_out_if.source out_o,
  sdm_cfg_if.sink   cfg_i
);
  import sdm_pkg::*;

  logic [7:0]  mux_divide_q;
  logic [15:0] scroll_divide_q;
  logic [7:0]  tick_count_q, tick_count_d;
  logic [15:0] scroll_count_q, scroll_count_d;
  logic [1:0]  digit_index_q, digit_index_d;
  logic [2:0]  scroll_offset_q, scroll_offset_d;
  logic [3:0]  message_select_q, message_select_d;

  logic        out_valid_q, out_valid_d;
  logic [3:0]  digit_en_n_q, digit_en_n_d;
  logic [13:0] segments_q, segments_d;

  logic        in_fire;
  logic        drive;
  logic [3:0]  pos;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid          = out_valid_q;
  assign out_o.digit_enable_n = digit_en_n_q;
  assign out_o.segments       = segments_q;

  assign pos = {1'b0, scroll_offset_q} + {2'b00, digit_index_q};

  always_comb begin
    tick_count_d     = tick_count_q;
    scroll_count_d   = scroll_count_q;
    digit_index_d    = digit_index_q;
    scroll_offset_d  = scroll_offset_q;
    message_select_d = message_select_q;
    drive            = 1'b0;
    digit_en_n_d     = ~(4'b0001 << digit_index_q);
    segments_d       = font_lookup(char_at(message_select_q, pos));

    if (in_fire) begin
      if (action_e'(in_i.action) == ACT_SELECT) begin
        if (in_i.select_value != message_select_q) begin
          message_select_d = in_i.select_value;
          scroll_offset_d  = '0;
        end
      end else if ({1'b0, tick_count_q} + 9'd1 < {1'b0, mux_divide_q}) begin
        tick_count_d = tick_count_q + 8'd1;
      end else begin
        tick_count_d  = '0;
        drive         = 1'b1;
        digit_index_d = digit_index_q + 2'd1;
        if ({1'b0, scroll_count_q} + 17'd1 < {1'b0, scroll_divide_q}) begin
          scroll_count_d = scroll_count_q + 16'd1;
        end else begin
          scroll_count_d = '0;
          // step while the offset plus three is within the message length, else wrap to the start
          if ({1'b0, scroll_offset_q} + 4'd3 <= msg_length(message_select_q)) begin
            scroll_offset_d = scroll_offset_q + 3'd1;
          end else begin
            scroll_offset_d = '0;
          end
        end
      end
    end

    if (drive) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mux_divide_q     <= 8'd5;
      scroll_divide_q  <= 16'd50;
      tick_count_q     <= '0;
      scroll_count_q   <= '0;
      digit_index_q    <= '0;
      scroll_offset_q  <= '0;
      message_select_q <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      tick_count_q     <= tick_count_d;
      scroll_count_q   <= scroll_count_d;
      digit_index_q    <= digit_index_d;
      scroll_offset_q  <= scroll_offset_d;
      message_select_q <= message_select_d;
      out_valid_q      <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_reg_e'(cfg_i.index))
          CFG_MUX_DIVIDE:    mux_divide_q    <= cfg_i.data[7:0];
          CFG_SCROLL_DIVIDE: scroll_divide_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  // payload holds while the result waits
  always_ff @(posedge clk_i) begin
    if (drive) begin
      digit_en_n_q <= digit_en_n_d;
      segments_q   <= segments_d;
    end
  end

  a_valid_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire && in_i.action == ACT_TICK))
    else $error("result appeared without a tick");

  a_select_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.action == ACT_SELECT && in_i.select_value != message_select_q)
    |=> (scroll_offset_q == 3'd0))
    else $error("scroll did not restart on new selection");

  a_one_cold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot(~digit_en_n_q))
    else $error("digit enable not one-cold");

  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scroll_offset_q <= 3'd4)
    else $error("scroll offset past message window");

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the scrolling 14-segment display driver: random and directed
// ticks and selector samples, each driven digit checked against a local model.
// Depends on sdm_pkg, the channel interfaces in sdm_if.sv and the top level.
`timescale 1ns / 100ps

module tb_top;
  import sdm_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int DrainCycles = 4;

  typedef struct packed {
    logic [3:0]  enable_n;
    logic [13:0] segments;
  } digit_t;

  // segment patterns of '0'-'9' then 'A'-'Z'
  localparam logic [13:0] GLYPHS [36] = '{
    14'h0c3f, 14'h0406, 14'h00db, 14'h008f, 14'h00e6, 14'h00ed, 14'h00fd, 14'h1401,
    14'h00ff, 14'h00e7, 14'h00f7, 14'h128f, 14'h0039, 14'h120f, 14'h00f9, 14'h00f1,
    14'h00bd, 14'h00f6, 14'h1209, 14'h001e, 14'h2470, 14'h0038, 14'h0536, 14'h2136,
    14'h003f, 14'h00f3, 14'h203f, 14'h20f3, 14'h018d, 14'h1201, 14'h003e, 14'h0c30,
    14'h2836, 14'h2d00, 14'h1500, 14'h0c09
  };

  string messages [4] = '{"ERROR", "AUTO", "MANUAL", "STOP"};

  logic clk;
  logic rst_n;

  sdm_in_if  in_ch ();
  sdm_out_if out_ch ();
  sdm_cfg_if cfg_ch ();

  scrolling_14seg_display_mux i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // display state as the block should hold it
  logic [7:0]  mux_div;
  logic [15:0] scroll_div;
  logic [7:0]  tick_cnt;
  logic [15:0] scroll_cnt;
  logic [1:0]  digit_idx;
  logic [2:0]  scroll_ofs;
  logic [3:0]  msg_sel;

  digit_t pending_digits [$];
  int     fail_count;
  bit     in_steady;
  bit     out_steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_display_state();
    mux_div    = 8'd5;
    scroll_div = 16'd50;
    tick_cnt   = '0;
    scroll_cnt = '0;
    digit_idx  = '0;
    scroll_ofs = '0;
    msg_sel    = '0;
  endfunction

  function automatic int message_length(logic [3:0] sel);
    if (sel >= 4) return 0;
    return messages[sel].len();
  endfunction

  function automatic byte unsigned message_char(logic [3:0] sel, int pos);
    if (pos >= message_length(sel) || pos >= 8) return 8'h00;
    return messages[sel][pos];
  endfunction

  function automatic logic [13:0] glyph(byte unsigned c);
    if (c >= 8'h30 && c <= 8'h39) return GLYPHS[int'(c) - 'h30];
    if (c >= 8'h41 && c <= 8'h5a) return GLYPHS[int'(c) - 'h41 + 10];
    return '0;
  endfunction

  // Advance the display state by one item and queue the digit it drives.
  function automatic void predict_digit(action_e act, logic [3:0] sel);
    digit_t d;
    int     pos;
    if (act == ACT_SELECT) begin
      if (sel != msg_sel) begin
        msg_sel    = sel;
        scroll_ofs = '0;
      end
      return;
    end
    if (int'(tick_cnt) + 1 < int'(mux_div)) begin
      tick_cnt = tick_cnt + 8'd1;
      return;
    end
    tick_cnt   = '0;
    pos        = int'(scroll_ofs) + int'(digit_idx);
    d.enable_n = ~(4'b0001 << digit_idx);
    d.segments = glyph(message_char(msg_sel, pos));
    pending_digits.push_back(d);
    digit_idx = digit_idx + 2'd1;
    if (int'(scroll_cnt) + 1 < int'(scroll_div)) begin
      scroll_cnt = scroll_cnt + 16'd1;
    end else begin
      scroll_cnt = '0;
      if (int'(scroll_ofs) + 3 <= message_length(msg_sel)) begin
        scroll_ofs = scroll_ofs + 3'd1;
      end else begin
        scroll_ofs = '0;
      end
    end
  endfunction

  // Called on a rising edge; returns on the edge that accepts the item.
  task automatic send_item(input action_e act, input logic [3:0] sel);
    int unsigned gap;
    gap = in_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.select_value <= sel;
    do @(posedge clk); while (!in_ch.ready);
    predict_digit(act, sel);
  endtask

  // Hold off until every driven digit is out and the block has settled.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
    wait_quiet();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_MUX_DIVIDE:    mux_div = value[7:0];
      CFG_SCROLL_DIVIDE: scroll_div = value;
      default: ;
    endcase
  endtask

  task automatic test_reset_state();
    // unchanged selection, then message 0 at the reset dividers
    send_item(ACT_SELECT, 4'd0);
    repeat (5) send_item(ACT_TICK, 4'($urandom_range(0, 15)));
  endtask

  task automatic test_selection();
    logic [3:0] picks [4];
    picks = '{4'd1, 4'd2, 4'd3, 4'd15};
    write_reg(CFG_MUX_DIVIDE, 16'd1);
    write_reg(CFG_SCROLL_DIVIDE, 16'd1);
    foreach (picks[i]) begin
      send_item(ACT_SELECT, picks[i]);
      send_item(ACT_TICK, ~picks[i]);
    end
    send_item(ACT_SELECT, 4'd15);
  endtask

  task automatic test_zero_divider();
    write_reg(CFG_MUX_DIVIDE, 16'd0);
    write_reg(CFG_SCROLL_DIVIDE, 16'd0);
    send_item(ACT_SELECT, 4'd2);
    repeat (4) send_item(ACT_TICK, 4'd0);
  endtask

  task automatic test_lowered_divider();
    write_reg(CFG_MUX_DIVIDE, 16'd1);
    write_reg(CFG_SCROLL_DIVIDE, 16'd5);
    repeat (3) send_item(ACT_TICK, 4'd0);
    // scroll count now sits past its new divider
    write_reg(CFG_SCROLL_DIVIDE, 16'd2);
    write_reg(CFG_MUX_DIVIDE, 16'd8);
    repeat (6) send_item(ACT_TICK, 4'd0);
    // tick count now sits past its new divider
    write_reg(CFG_MUX_DIVIDE, 16'd2);
    send_item(ACT_TICK, 4'd0);
  endtask

  task automatic run_random(input logic [7:0] mux, input logic [15:0] scroll, input int count);
    logic [3:0] sel;
    write_reg(CFG_MUX_DIVIDE, {8'($urandom), mux});
    write_reg(CFG_SCROLL_DIVIDE, scroll);
    in_steady  = ($urandom_range(0, 3) == 0);
    out_steady = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        sel = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(4, 15));
        send_item(ACT_SELECT, sel);
      end else begin
        send_item(ACT_TICK, 4'($urandom));
      end
    end
    in_steady  = 1'b0;
    out_steady = 1'b0;
  endtask

  task automatic test_random_phases();
    run_random(8'd1, 16'd1, 150);
    run_random(8'd2, 16'd3, 150);
    run_random(8'd1, 16'hffff, 80);
    run_random(8'd255, 16'd1, 270);
    run_random(8'd0, 16'd0, 100);
    run_random(8'($urandom_range(1, 6)), 16'($urandom_range(1, 12)), 100);
  endtask

  initial begin
    reset_display_state();
    fail_count = 0;
    in_steady  = 1'b0;
    out_steady = 1'b0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_TICK;
    in_ch.select_value <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_MUX_DIVIDE;
    cfg_ch.data        <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_selection();
    test_zero_divider();
    test_lowered_divider();
    test_random_phases();

    in_ch.valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("scrolling_14seg_display_mux test passed");
    end else begin
      $display("scrolling_14seg_display_mux test failed");
    end
    $finish;
  end

  // Digit receiver: stall at random, then check each digit taken.
  initial begin
    digit_t     want;
    int unsigned hold;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = out_steady ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      if (pending_digits.size() == 0) begin
        $error("unexpected digit: digit_enable_n %h segments %h",
               out_ch.digit_enable_n, out_ch.segments);
        fail_count++;
      end else begin
        want = pending_digits.pop_front();
        if (out_ch.digit_enable_n !== want.enable_n) begin
          $error("digit_enable_n: expected %h, got %h", want.enable_n, out_ch.digit_enable_n);
          fail_count++;
        end
        if (out_ch.segments !== want.segments) begin
          $error("segments: expected %h, got %h", want.segments, out_ch.segments);
          fail_count++;
        end
      end
    end
  end

  // Drop the run once no channel has moved an item for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("scrolling_14seg_display_mux test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sdm_pkg.sv
design/sdm_if.sv
design/scrolling_14seg_display_mux.sv
tb/tb_top.sv
